>>> src/cfl_pkg.sv
package cfl_pkg;

  // Lexical states
  localparam logic [2:0] LX_CODE   = 3'd0;
  localparam logic [2:0] LX_COPEN  = 3'd1;
  localparam logic [2:0] LX_BLOCK  = 3'd2;
  localparam logic [2:0] LX_LINE   = 3'd3;
  localparam logic [2:0] LX_CCLOSE = 3'd4;
  localparam logic [2:0] LX_STR    = 3'd5;
  localparam logic [2:0] LX_CHR    = 3'd6;
  localparam logic [2:0] LX_ESC    = 3'd7;

  // Function header states
  localparam logic [3:0] HD_SPACE     = 4'd0;
  localparam logic [3:0] HD_FINAL     = 4'd1;
  localparam logic [3:0] HD_NAME      = 4'd2;
  localparam logic [3:0] HD_TRAIL     = 4'd3;
  localparam logic [3:0] HD_OPEN      = 4'd4;
  localparam logic [3:0] HD_OPEN2     = 4'd5;
  localparam logic [3:0] HD_CLOSE     = 4'd6;
  localparam logic [3:0] HD_ARG       = 4'd7;
  localparam logic [3:0] HD_SEMI      = 4'd8;
  localparam logic [3:0] HD_BODY      = 4'd9;
  localparam logic [3:0] HD_MACRO     = 4'd10;
  localparam logic [3:0] HD_MACRO_ESC = 4'd11;

  // Character codes
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // Control from the lexer to the depth counter and header machine
  typedef struct packed {
    logic       italic;
    logic       prior;
    logic       depth_inc;
    logic       depth_dec;
    logic       code_open;    // '{' seen in code
    logic       code_close;   // '}' seen in code
    logic       copen_close;  // '}' right after a lone slash
    logic       run_header;
  } lex_ctl_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_BLANK || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

>>> src/cfl_lex.sv
module cfl_lex (
  input  logic [7:0]        c,
  input  logic [2:0]        lex_cur,
  input  logic [2:0]        ret_cur,
  output logic [2:0]        lex_next,
  output logic [2:0]        ret_next,
  output cfl_pkg::lex_ctl_t ctl
);

  // Lexical machine, one character per pass
  always_comb begin
    lex_next = lex_cur;
    ret_next = ret_cur;
    ctl = '0;
    case (lex_cur)
      cfl_pkg::LX_CODE: begin
        if (c == cfl_pkg::CH_SLASH) begin
          lex_next = cfl_pkg::LX_COPEN;
        end else if (c == cfl_pkg::CH_LBRACE) begin
          ctl.depth_inc = 1'b1;
          ctl.code_open = 1'b1;
        end else if (c == cfl_pkg::CH_RBRACE) begin
          ctl.depth_dec  = 1'b1;
          ctl.code_close = 1'b1;
        end else if (c == cfl_pkg::CH_DQUOTE) begin
          lex_next = cfl_pkg::LX_STR;
        end else if (c == cfl_pkg::CH_SQUOTE) begin
          lex_next = cfl_pkg::LX_CHR;
        end
      end
      cfl_pkg::LX_COPEN: begin
        if (c == cfl_pkg::CH_SLASH) begin
          lex_next = cfl_pkg::LX_LINE;
          ctl.italic = 1'b1;
          ctl.prior = 1'b1;
        end else if (c == cfl_pkg::CH_STAR) begin
          lex_next = cfl_pkg::LX_BLOCK;
          ctl.italic = 1'b1;
          ctl.prior = 1'b1;
        end else if (c == cfl_pkg::CH_LBRACE) begin
          lex_next = cfl_pkg::LX_CODE;
          ctl.depth_inc = 1'b1;
        end else if (c == cfl_pkg::CH_RBRACE) begin
          // stays in comment open
          ctl.depth_dec   = 1'b1;
          ctl.copen_close = 1'b1;
        end else begin
          lex_next = cfl_pkg::LX_CODE;
        end
      end
      cfl_pkg::LX_BLOCK: begin
        ctl.italic = 1'b1;
        if (c == cfl_pkg::CH_STAR) lex_next = cfl_pkg::LX_CCLOSE;
      end
      cfl_pkg::LX_LINE: begin
        ctl.italic = 1'b1;
        if (c == cfl_pkg::CH_NL) lex_next = cfl_pkg::LX_CODE;
      end
      cfl_pkg::LX_CCLOSE: begin
        ctl.italic = 1'b1;
        if (c == cfl_pkg::CH_SLASH) lex_next = cfl_pkg::LX_CODE;
        else if (c != cfl_pkg::CH_STAR) lex_next = cfl_pkg::LX_BLOCK;
      end
      cfl_pkg::LX_STR: begin
        if (c == cfl_pkg::CH_DQUOTE) begin
          lex_next = cfl_pkg::LX_CODE;
        end else if (c == cfl_pkg::CH_BSLASH) begin
          ret_next = cfl_pkg::LX_STR;
          lex_next = cfl_pkg::LX_ESC;
        end
      end
      cfl_pkg::LX_CHR: begin
        if (c == cfl_pkg::CH_SQUOTE) begin
          lex_next = cfl_pkg::LX_CODE;
        end else if (c == cfl_pkg::CH_BSLASH) begin
          ret_next = cfl_pkg::LX_CHR;
          lex_next = cfl_pkg::LX_ESC;
        end
      end
      default: begin
        // escape: back to the string or char literal
        lex_next = ret_cur;
      end
    endcase
    ctl.run_header = (lex_next == cfl_pkg::LX_CODE) && (lex_cur != cfl_pkg::LX_CCLOSE);
  end

endmodule

>>> src/cfl_depth.sv
module cfl_depth #(
  parameter int DEPTH_BITS = 16
) (
  input  logic                  inc,
  input  logic                  dec,
  input  logic [DEPTH_BITS-1:0] depth,
  output logic [DEPTH_BITS-1:0] depth_next,
  output logic                  zero_hit
);

  localparam logic [DEPTH_BITS-1:0] DepthMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic [DEPTH_BITS-1:0] DepthMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic [DEPTH_BITS-1:0] DepthOne = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

  // Saturating signed brace counter
  always_comb begin
    depth_next = depth;
    zero_hit = 1'b0;
    if (inc) begin
      if (depth != DepthMax) depth_next = depth + DepthOne;
    end else if (dec) begin
      if (depth != DepthMin) begin
        depth_next = depth - DepthOne;
        zero_hit = (depth == DepthOne);
      end
    end
  end

endmodule

>>> src/cfl_hdr.sv
module cfl_hdr #(
  parameter int POSITION_BITS = 32,
  parameter int PAGE_BITS     = 16
) (
  input  logic [7:0]               c,
  input  logic [POSITION_BITS-1:0] pos,
  input  logic [PAGE_BITS-1:0]     pg,
  input  cfl_pkg::lex_ctl_t        ctl,
  input  logic                     zero_hit,
  input  logic [3:0]               hdr_cur,
  input  logic [3:0]               hret_cur,
  input  logic [POSITION_BITS-1:0] start_cur,
  input  logic [POSITION_BITS-1:0] end_cur,
  input  logic [PAGE_BITS-1:0]     spage_cur,
  output logic [3:0]               hdr_next,
  output logic [3:0]               hret_next,
  output logic [POSITION_BITS-1:0] start_next,
  output logic [POSITION_BITS-1:0] end_next,
  output logic [PAGE_BITS-1:0]     spage_next,
  output logic                     found,
  output logic                     fend
);

  localparam logic [POSITION_BITS-1:0] PosOne = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  logic [3:0] hdr_mid;
  logic       c_alpha;
  logic       c_space;
  logic       c_word;
  logic [POSITION_BITS-1:0] pos_prev;

  assign c_alpha  = cfl_pkg::is_alpha(c);
  assign c_space  = cfl_pkg::is_space(c);
  assign c_word   = c_alpha || cfl_pkg::is_digit(c) || c == cfl_pkg::CH_UNDER;
  assign pos_prev = pos - PosOne;

  // Brace effects on the header state, before the header pass
  always_comb begin
    hdr_mid = hdr_cur;
    found = 1'b0;
    fend = 1'b0;
    if (ctl.code_open && (hdr_cur == cfl_pkg::HD_CLOSE || hdr_cur == cfl_pkg::HD_SEMI)) begin
      found = 1'b1;
      hdr_mid = cfl_pkg::HD_BODY;
    end
    if (ctl.code_close && zero_hit && hdr_cur == cfl_pkg::HD_BODY) begin
      fend = 1'b1;
      hdr_mid = cfl_pkg::HD_SPACE;
    end
    if (ctl.copen_close && zero_hit) fend = 1'b1;
  end

  // Header recognizer: name ( ... ) [old-style args ;] {
  always_comb begin
    hdr_next = hdr_mid;
    hret_next = hret_cur;
    start_next = start_cur;
    end_next = end_cur;
    spage_next = spage_cur;
    if (ctl.run_header) begin
      case (hdr_mid)
        cfl_pkg::HD_SPACE: begin
          if (c_alpha) begin
            spage_next = pg;
            start_next = pos;
            hdr_next = cfl_pkg::HD_NAME;
          end else if (c == cfl_pkg::CH_HASH) begin
            hret_next = cfl_pkg::HD_SPACE;
            hdr_next = cfl_pkg::HD_MACRO;
          end
        end
        cfl_pkg::HD_MACRO: begin
          if (c == cfl_pkg::CH_BSLASH) hdr_next = cfl_pkg::HD_MACRO_ESC;
          else if (c == cfl_pkg::CH_NL) hdr_next = hret_cur;
        end
        cfl_pkg::HD_MACRO_ESC: begin
          hdr_next = cfl_pkg::HD_MACRO;
        end
        cfl_pkg::HD_NAME: begin
          if (!c_word) begin
            if (c_space) begin
              end_next = pos_prev;
              hdr_next = cfl_pkg::HD_TRAIL;
            end else if (c == cfl_pkg::CH_LPAREN) begin
              end_next = pos_prev;
              hdr_next = cfl_pkg::HD_OPEN;
            end else begin
              hdr_next = cfl_pkg::HD_SPACE;
            end
          end
        end
        cfl_pkg::HD_TRAIL: begin
          if (!c_space) begin
            if (c == cfl_pkg::CH_LPAREN) begin
              hdr_next = cfl_pkg::HD_OPEN;
            end else if (c_alpha) begin
              spage_next = pg;
              start_next = pos;
              hdr_next = cfl_pkg::HD_NAME;
            end else begin
              hdr_next = cfl_pkg::HD_SPACE;
            end
          end
        end
        cfl_pkg::HD_OPEN: begin
          if (c == cfl_pkg::CH_LPAREN) hdr_next = cfl_pkg::HD_OPEN2;
          else if (c == cfl_pkg::CH_RPAREN) hdr_next = cfl_pkg::HD_CLOSE;
        end
        cfl_pkg::HD_OPEN2: begin
          if (c == cfl_pkg::CH_RPAREN) hdr_next = cfl_pkg::HD_OPEN;
        end
        cfl_pkg::HD_CLOSE: begin
          if (!c_space) begin
            if (c_alpha || c == cfl_pkg::CH_LBRACK) hdr_next = cfl_pkg::HD_ARG;
            else hdr_next = cfl_pkg::HD_SPACE;
          end
        end
        cfl_pkg::HD_ARG: begin
          if (c == cfl_pkg::CH_SEMI || c == cfl_pkg::CH_RBRACK) hdr_next = cfl_pkg::HD_SEMI;
        end
        cfl_pkg::HD_SEMI: begin
          if (!c_space && c != cfl_pkg::CH_SEMI) hdr_next = cfl_pkg::HD_ARG;
        end
        default: begin
          hdr_next = hdr_mid;
        end
      endcase
    end
  end

endmodule

>>> src/c_source_function_locator.sv
// An accepted character beat passes the input register, then the result register.
// Throughput: one character per cycle unless result_stall holds a full result
// register; the lexer, header machine and depth counter update together in the
// single logic stage between the input and result registers.
// Reset (synchronous): both stages empty, lexer in code, header machine in
// initial space, depth and name marks zero.
module c_source_function_locator #(
  parameter int POSITION_BITS = 32,
  parameter int PAGE_BITS     = 16,
  parameter int DEPTH_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         char_valid,
  output logic                         char_stall,
  input  logic [7:0]                   char_code,
  input  logic [POSITION_BITS-1:0]     char_position,
  input  logic [PAGE_BITS-1:0]         page,
  input  logic                         restart,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         italic,
  output logic                         prior_opens_comment,
  output logic                         function_found,
  output logic                         function_end,
  output logic [POSITION_BITS-1:0]     name_start,
  output logic [POSITION_BITS-1:0]     name_end,
  output logic [PAGE_BITS-1:0]         name_page,
  output logic signed [DEPTH_BITS-1:0] brace_depth
);

  // Input register
  logic                     in_valid;
  logic [7:0]               in_code;
  logic [POSITION_BITS-1:0] in_pos;
  logic [PAGE_BITS-1:0]     in_page;
  logic                     in_restart;

  // Parser state
  logic [2:0]               lex_state;
  logic [2:0]               lex_return_state;
  logic [3:0]               header_state;
  logic [3:0]               header_return_state;
  logic [DEPTH_BITS-1:0]    depth_count;
  logic [POSITION_BITS-1:0] start_mark;
  logic [POSITION_BITS-1:0] end_mark;
  logic [PAGE_BITS-1:0]     start_page;

  // State seen by this character, after an optional restart
  logic [2:0]               lex_cur;
  logic [2:0]               ret_cur;
  logic [3:0]               hdr_cur;
  logic [3:0]               hret_cur;
  logic [DEPTH_BITS-1:0]    depth_cur;
  logic [POSITION_BITS-1:0] start_cur;
  logic [POSITION_BITS-1:0] end_cur;
  logic [PAGE_BITS-1:0]     spage_cur;

  logic [2:0]               lex_state_next;
  logic [2:0]               lex_return_state_next;
  logic [3:0]               header_state_next;
  logic [3:0]               header_return_state_next;
  logic [DEPTH_BITS-1:0]    depth_count_next;
  logic [POSITION_BITS-1:0] start_mark_next;
  logic [POSITION_BITS-1:0] end_mark_next;
  logic [PAGE_BITS-1:0]     start_page_next;

  cfl_pkg::lex_ctl_t ctl;
  logic zero_hit;
  logic found;
  logic fend;
  logic advance;

  // Stage handshake: the input stage moves on when the result register is empty or not stalled
  assign advance    = in_valid && (!result_valid || !result_stall);
  assign char_stall = in_valid && result_valid && result_stall;

  assign lex_cur   = in_restart ? cfl_pkg::LX_CODE  : lex_state;
  assign ret_cur   = in_restart ? cfl_pkg::LX_CODE  : lex_return_state;
  assign hdr_cur   = in_restart ? cfl_pkg::HD_SPACE : header_state;
  assign hret_cur  = in_restart ? cfl_pkg::HD_SPACE : header_return_state;
  assign depth_cur = in_restart ? '0 : depth_count;
  assign start_cur = in_restart ? '0 : start_mark;
  assign end_cur   = in_restart ? '0 : end_mark;
  assign spage_cur = in_restart ? '0 : start_page;

  cfl_lex u_lex (
    .c        (in_code),
    .lex_cur  (lex_cur),
    .ret_cur  (ret_cur),
    .lex_next (lex_state_next),
    .ret_next (lex_return_state_next),
    .ctl      (ctl)
  );

  cfl_depth #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_depth (
    .inc        (ctl.depth_inc),
    .dec        (ctl.depth_dec),
    .depth      (depth_cur),
    .depth_next (depth_count_next),
    .zero_hit   (zero_hit)
  );

  cfl_hdr #(
    .POSITION_BITS (POSITION_BITS),
    .PAGE_BITS     (PAGE_BITS)
  ) u_hdr (
    .c          (in_code),
    .pos        (in_pos),
    .pg         (in_page),
    .ctl        (ctl),
    .zero_hit   (zero_hit),
    .hdr_cur    (hdr_cur),
    .hret_cur   (hret_cur),
    .start_cur  (start_cur),
    .end_cur    (end_cur),
    .spage_cur  (spage_cur),
    .hdr_next   (header_state_next),
    .hret_next  (header_return_state_next),
    .start_next (start_mark_next),
    .end_next   (end_mark_next),
    .spage_next (start_page_next),
    .found      (found),
    .fend       (fend)
  );

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!char_stall) begin
      in_valid <= char_valid;
    end
    if (char_valid && !char_stall) begin
      in_code    <= char_code;
      in_pos     <= char_position;
      in_page    <= page;
      in_restart <= restart;
    end
  end

  // Parser state, updated as each beat moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state           <= cfl_pkg::LX_CODE;
      lex_return_state    <= cfl_pkg::LX_CODE;
      header_state        <= cfl_pkg::HD_SPACE;
      header_return_state <= cfl_pkg::HD_SPACE;
      depth_count         <= '0;
      start_mark          <= '0;
      end_mark            <= '0;
      start_page          <= '0;
    end else if (advance) begin
      lex_state           <= lex_state_next;
      lex_return_state    <= lex_return_state_next;
      header_state        <= header_state_next;
      header_return_state <= header_return_state_next;
      depth_count         <= depth_count_next;
      start_mark          <= start_mark_next;
      end_mark            <= end_mark_next;
      start_page          <= start_page_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      italic              <= ctl.italic;
      prior_opens_comment <= ctl.prior;
      function_found      <= found;
      function_end        <= fend;
      name_start          <= found ? start_cur : '0;
      name_end            <= found ? end_cur : '0;
      name_page           <= found ? spage_cur : '0;
      brace_depth         <= $signed(depth_count_next);
    end
  end

endmodule
